FILE: rtl/spf_pkg.sv
// shared types, constants and register codes for the spectrum peak detector
`default_nettype none

package spf_pkg;

    // field widths
    localparam int BIN_W      = 10;
    localparam int MAG_W      = 16;
    localparam int SUM_W      = 24;
    localparam int AVG_W      = 24;
    localparam int FRAC_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // parameter defaults
    localparam int FRAME_BINS_DEF    = 1024;
    localparam int NOISE_DIVISOR_DEF = 186;
    localparam int MAG_BITS_DEF      = 16;

    // register reset values
    localparam logic [BIN_W-1:0] WINDOW_FIRST_RST = BIN_W'(4);
    localparam logic [BIN_W-1:0] WINDOW_LAST_RST  = BIN_W'(192);
    localparam logic [MAG_W-1:0] START_FLOOR_RST  = '0;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    // divide by three through a reciprocal, exact for dividends below 2^(AVG_W+2)
    localparam int DIV3_IN_W  = AVG_W + 2;
    localparam int DIV3_SHIFT = AVG_W + 4;
    localparam int DIV3_MUL_W = AVG_W + 3;
    localparam logic [DIV3_MUL_W-1:0] DIV3_MUL =
        DIV3_MUL_W'(((64'd1 << DIV3_SHIFT) + 64'd2) / 64'd3);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_FIRST = 2'd0,
        CFG_WINDOW_LAST  = 2'd1,
        CFG_START_FLOOR  = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [BIN_W-1:0] window_first;
        logic [BIN_W-1:0] window_last;
        logic [MAG_W-1:0] start_floor;
    } cfg_t;

    // peak data carried along the evaluation pipeline
    typedef struct packed {
        logic [BIN_W-1:0] peak_idx;
        logic [MAG_W-1:0] peak_mag;
        logic             max_valid;
    } peak_info_t;

    // frame totals captured on the last bin
    typedef struct packed {
        peak_info_t       peak;
        logic [MAG_W-1:0] left;
        logic [MAG_W-1:0] right;
        logic [SUM_W-1:0] sum;
        logic             clr;
    } frame_eval_t;

    // evaluated frame ahead of the peak decision
    typedef struct packed {
        peak_info_t       peak;
        logic [AVG_W-1:0] avg;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/spf_frame_track.sv
// per-bin tracking of window sum, running maximum and its neighbors
`default_nettype none

module spf_frame_track #(
    parameter int FRAME_BINS = spf_pkg::FRAME_BINS_DEF,
    parameter int MAG_BITS   = spf_pkg::MAG_BITS_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire spf_pkg::cfg_t             cfg,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [spf_pkg::MAG_W-1:0] s_magnitude,
    input  wire logic                      s_last_of_frame,
    input  wire logic                      s_clear_average,
    output logic                           e_valid,
    input  wire logic                      e_ready,
    output spf_pkg::frame_eval_t           e_data
);

    localparam int MW    = spf_pkg::MAG_W;
    localparam int BW    = spf_pkg::BIN_W;
    localparam int SW    = spf_pkg::SUM_W;
    localparam int CNT_W = $clog2(FRAME_BINS);
    localparam int CMP_W = (CNT_W > BW) ? CNT_W : BW;
    localparam logic [MW-1:0] MAG_MASK =
        (MAG_BITS >= MW) ? {MW{1'b1}} : MW'((64'd1 << MAG_BITS) - 64'd1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAME_BINS - 1);

    logic [CNT_W-1:0] bin_cnt_reg,    bin_cnt_next;
    logic [MW-1:0]    run_max_reg,    run_max_next;
    logic [BW-1:0]    max_idx_reg,    max_idx_next;
    logic             max_valid_reg,  max_valid_next;
    logic [MW-1:0]    left_reg,       left_next;
    logic [MW-1:0]    right_reg,      right_next;
    logic             right_pend_reg, right_pend_next;
    logic [MW-1:0]    prev_reg,       prev_next;
    logic [SW-1:0]    sum_reg,        sum_next;
    logic             e_valid_reg,    e_valid_next;
    spf_pkg::frame_eval_t e_reg,      e_next;

    logic             s_accept;
    logic [MW-1:0]    mag;
    logic [CMP_W-1:0] idx_ext;
    logic             in_win;
    logic [MW-1:0]    thr;
    logic [SW:0]      sum_add;
    logic [SW-1:0]    sum_sat;
    logic             new_max;
    logic [MW-1:0]    up_max;
    logic [BW-1:0]    up_idx;
    logic             up_valid;
    logic [MW-1:0]    up_left;
    logic [MW-1:0]    up_right;
    logic [SW-1:0]    up_sum;

    assign s_ready  = !e_valid_reg || e_ready;
    assign s_accept = s_valid && s_ready;
    assign e_valid  = e_valid_reg;
    assign e_data   = e_reg;

    // state after this bin
    always_comb begin
        mag      = s_magnitude & MAG_MASK;
        idx_ext  = CMP_W'(bin_cnt_reg);
        in_win   = (idx_ext >= CMP_W'(cfg.window_first)) &&
                   (idx_ext <= CMP_W'(cfg.window_last));
        thr      = max_valid_reg ? run_max_reg : cfg.start_floor;
        sum_add  = {1'b0, sum_reg} + (SW + 1)'(mag);
        sum_sat  = sum_add[SW] ? spf_pkg::SUM_MAX : sum_add[SW-1:0];
        new_max  = in_win && (mag > thr);
        up_max   = new_max ? mag : run_max_reg;
        up_idx   = new_max ? idx_ext[BW-1:0] : max_idx_reg;
        up_valid = new_max || max_valid_reg;
        up_left  = new_max ? prev_reg : left_reg;
        up_right = new_max ? '0 : (right_pend_reg ? mag : right_reg);
        up_sum   = in_win ? sum_sat : sum_reg;
    end

    // next state, cleared after the last bin
    always_comb begin
        bin_cnt_next    = bin_cnt_reg;
        run_max_next    = run_max_reg;
        max_idx_next    = max_idx_reg;
        max_valid_next  = max_valid_reg;
        left_next       = left_reg;
        right_next      = right_reg;
        right_pend_next = right_pend_reg;
        prev_next       = prev_reg;
        sum_next        = sum_reg;
        if (s_accept) begin
            if (s_last_of_frame) begin
                bin_cnt_next    = '0;
                run_max_next    = cfg.start_floor;
                max_idx_next    = '0;
                max_valid_next  = 1'b0;
                left_next       = '0;
                right_next      = '0;
                right_pend_next = 1'b0;
                prev_next       = '0;
                sum_next        = '0;
            end else begin
                bin_cnt_next    = (bin_cnt_reg == CNT_LAST) ? '0 : bin_cnt_reg + 1'b1;
                run_max_next    = up_max;
                max_idx_next    = up_idx;
                max_valid_next  = up_valid;
                left_next       = up_left;
                right_next      = up_right;
                right_pend_next = new_max;
                prev_next       = mag;
                sum_next        = up_sum;
            end
        end
    end

    // frame totals handed to the evaluation pipeline
    always_comb begin
        e_valid_next = e_valid_reg && !e_ready;
        e_next       = e_reg;
        if (s_accept && s_last_of_frame) begin
            e_valid_next           = 1'b1;
            e_next.peak.peak_idx   = up_idx;
            e_next.peak.peak_mag   = up_valid ? up_max : cfg.start_floor;
            e_next.peak.max_valid  = up_valid;
            e_next.left            = up_left;
            e_next.right           = up_right;
            e_next.sum             = up_sum;
            e_next.clr             = s_clear_average;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_cnt_reg    <= '0;
            max_valid_reg  <= 1'b0;
            left_reg       <= '0;
            right_reg      <= '0;
            right_pend_reg <= 1'b0;
            prev_reg       <= '0;
            sum_reg        <= '0;
            e_valid_reg    <= 1'b0;
        end else begin
            bin_cnt_reg    <= bin_cnt_next;
            max_valid_reg  <= max_valid_next;
            left_reg       <= left_next;
            right_reg      <= right_next;
            right_pend_reg <= right_pend_next;
            prev_reg       <= prev_next;
            sum_reg        <= sum_next;
            e_valid_reg    <= e_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        run_max_reg <= run_max_next;
        max_idx_reg <= max_idx_next;
        e_reg       <= e_next;
    end

`ifndef NO_ASSERTIONS
    // last bin restarts the frame and queues an evaluation
    a_last_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_last_of_frame) |=>
            (bin_cnt_reg == '0) && !max_valid_reg && !right_pend_reg && e_valid_reg)
        else $error("frame state not cleared after last bin");

    // bin counter moves only on an accepted word
    a_cnt_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_accept |=> $stable(bin_cnt_reg))
        else $error("bin counter moved without an accepted word");
`endif

endmodule

`default_nettype wire

FILE: rtl/spf_noise_calc.sv
// noise figure, smoothed noise average and peak data pipeline
`default_nettype none

module spf_noise_calc #(
    parameter int NOISE_DIVISOR = spf_pkg::NOISE_DIVISOR_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 e_valid,
    output logic                      e_ready,
    input  wire spf_pkg::frame_eval_t e_data,
    output logic                      r_valid,
    input  wire logic                 r_ready,
    output spf_pkg::result_t          r_data
);

    localparam int SW       = spf_pkg::SUM_W;
    localparam int AW       = spf_pkg::AVG_W;
    localparam int DIV_LOG  = $clog2(NOISE_DIVISOR);
    localparam int RECIP_SH = SW + DIV_LOG;
    localparam int RECIP_W  = SW + spf_pkg::FRAC_W + 1;
    localparam int PROD_W   = SW + RECIP_W;
    localparam int Q_W      = spf_pkg::DIV3_IN_W + spf_pkg::DIV3_MUL_W;
    // ceil(2^(RECIP_SH+8)/NOISE_DIVISOR), exact for 24-bit dividends
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(
        ((64'd1 << (RECIP_SH + spf_pkg::FRAC_W)) + 64'(NOISE_DIVISOR) - 64'd1) /
        64'(NOISE_DIVISOR));

    logic                s2_valid_reg, s3_valid_reg, s4_valid_reg;
    spf_pkg::peak_info_t s2_peak_reg,  s3_peak_reg;
    logic                s2_clr_reg,   s3_clr_reg;
    logic [SW-1:0]       s2_diff_reg;
    logic [PROD_W-1:0]   s3_prod_reg;
    spf_pkg::result_t    s4_reg;
    logic [AW-1:0]       avg_reg,      avg_next;

    logic rdy2, rdy3, rdy4;

    logic [spf_pkg::MAG_W+1:0]          excl;
    logic [SW-1:0]                      diff;
    logic [PROD_W-1:0]                  prod;
    logic [PROD_W-1:0]                  noise_sh;
    logic [SW-1:0]                      noise_sat;
    logic [AW-1:0]                      prev_avg;
    logic [spf_pkg::DIV3_IN_W-1:0]      div3_in;
    logic [Q_W-1:0]                     div3_prod;

    // stall chain
    assign rdy4    = !s4_valid_reg || r_ready;
    assign rdy3    = !s3_valid_reg || rdy4;
    assign rdy2    = !s2_valid_reg || rdy3;
    assign e_ready = rdy2;
    assign r_valid = s4_valid_reg;
    assign r_data  = s4_reg;

    // window sum less peak and neighbors, clamped at zero
    always_comb begin
        excl = '0;
        if (e_data.peak.max_valid) begin
            excl = (spf_pkg::MAG_W + 2)'(e_data.peak.peak_mag) +
                   (spf_pkg::MAG_W + 2)'(e_data.left) +
                   (spf_pkg::MAG_W + 2)'(e_data.right);
        end
        diff = (e_data.sum > SW'(excl)) ? e_data.sum - SW'(excl) : '0;
    end

    // scale by 256 over the divisor
    assign prod = s2_diff_reg * RECIP;

    // saturate noise and smooth as (2*avg + noise) / 3
    always_comb begin
        noise_sh  = s3_prod_reg >> RECIP_SH;
        noise_sat = (noise_sh > PROD_W'(spf_pkg::SUM_MAX)) ? spf_pkg::SUM_MAX
                                                            : noise_sh[SW-1:0];
        prev_avg  = s3_clr_reg ? '0 : avg_reg;
        div3_in   = {1'b0, prev_avg, 1'b0} + spf_pkg::DIV3_IN_W'(noise_sat);
        div3_prod = div3_in * spf_pkg::DIV3_MUL;
        avg_next  = div3_prod[spf_pkg::DIV3_SHIFT +: AW];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            avg_reg      <= '0;
        end else begin
            if (rdy2) begin
                s2_valid_reg <= e_valid;
            end
            if (rdy3) begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (rdy4) begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (rdy4 && s3_valid_reg) begin
                avg_reg <= avg_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy2 && e_valid) begin
            s2_peak_reg <= e_data.peak;
            s2_clr_reg  <= e_data.clr;
            s2_diff_reg <= diff;
        end
        if (rdy3 && s2_valid_reg) begin
            s3_peak_reg <= s2_peak_reg;
            s3_clr_reg  <= s2_clr_reg;
            s3_prod_reg <= prod;
        end
        if (rdy4 && s3_valid_reg) begin
            s4_reg.peak <= s3_peak_reg;
            s4_reg.avg  <= avg_next;
        end
    end

`ifndef NO_ASSERTIONS
    // the average changes only when a frame moves into the last stage
    a_avg_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s3_valid_reg && rdy4) |=> $stable(avg_reg))
        else $error("noise average changed without a frame");

    // the last stage carries the latest average
    a_avg_copy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s3_valid_reg && rdy4) |=> (s4_reg.avg == avg_reg) && s4_valid_reg)
        else $error("stage average differs from running average");
`endif

endmodule

`default_nettype wire

FILE: rtl/spf_result.sv
// peak decision against twice the average and the result register
`default_nettype none

module spf_result (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      r_valid,
    output logic                           r_ready,
    input  wire spf_pkg::result_t          r_data,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [spf_pkg::BIN_W-1:0]      m_peak_bin,
    output logic [spf_pkg::MAG_W-1:0]      m_peak_magnitude,
    output logic [spf_pkg::MAG_W-1:0]      m_noise_level,
    output logic                           m_peak_found
);

    localparam int CW = spf_pkg::AVG_W + 1;

    logic                      m_valid_reg;
    logic [spf_pkg::BIN_W-1:0] peak_bin_reg;
    logic [spf_pkg::MAG_W-1:0] peak_mag_reg;
    logic [spf_pkg::MAG_W-1:0] noise_reg;
    logic                      found_reg;

    logic [CW-1:0] peak_scaled;
    logic [CW-1:0] avg_twice;
    logic          found;

    assign r_ready = !m_valid_reg || m_ready;

    // peak in 16.8 against twice the average
    always_comb begin
        peak_scaled = CW'({r_data.peak.peak_mag, {spf_pkg::FRAC_W{1'b0}}});
        avg_twice   = {r_data.avg, 1'b0};
        found       = r_data.peak.max_valid && (peak_scaled > avg_twice);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (r_ready) begin
            m_valid_reg <= r_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (r_ready && r_valid) begin
            peak_bin_reg <= found ? r_data.peak.peak_idx : '0;
            peak_mag_reg <= r_data.peak.peak_mag;
            noise_reg    <= r_data.avg[spf_pkg::FRAC_W +: spf_pkg::MAG_W];
            found_reg    <= found;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_peak_bin       = peak_bin_reg;
    assign m_peak_magnitude = peak_mag_reg;
    assign m_noise_level    = noise_reg;
    assign m_peak_found     = found_reg;

`ifndef NO_ASSERTIONS
    // no peak reports bin zero
    a_no_peak_bin: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !found_reg) |-> (peak_bin_reg == '0))
        else $error("peak bin set without a peak");
`endif

endmodule

`default_nettype wire

FILE: rtl/spectrum_peak_with_noise_floor.sv
// top level of the spectrum peak detector with smoothed noise floor
//
// Spectrum magnitude bins enter on the s_ channel, one word per bin, with
// s_last_of_frame on the final bin. The bin index counts from zero at the
// start of each frame. Bins are taken at one per cycle, back to back, while
// s_ready is high. Non-final bins give no result; the final bin gives one
// word on the m_ channel: peak bin, peak magnitude, noise level and
// peak-found flag. After the final bin is accepted, the frame passes the
// frame capture register, the clamped difference stage, the reciprocal
// multiply by the noise divisor, the divide by three of the average and
// the result register. The average loop closes in that one divide stage,
// so final bins may also come every cycle while the receiver keeps up.
// When the receiver stalls, bins keep flowing until five finished frames
// are held, the one on the m_ channel included; then s_ready drops until m_ready.
// The cfg channel writes window_first_bin, window_last_bin and start_floor
// by index, always ready; write them only while the block is idle.
// Reset restores the default window 4..192, a zero floor and a zero average,
// and empties the pipeline.
`default_nettype none

module spectrum_peak_with_noise_floor #(
    parameter int FRAME_BINS    = spf_pkg::FRAME_BINS_DEF,
    parameter int NOISE_DIVISOR = spf_pkg::NOISE_DIVISOR_DEF,
    parameter int MAG_BITS      = spf_pkg::MAG_BITS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [spf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [spf_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [spf_pkg::MAG_W-1:0]      s_magnitude,
    input  wire logic                           s_last_of_frame,
    input  wire logic                           s_clear_average,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [spf_pkg::BIN_W-1:0]           m_peak_bin,
    output logic [spf_pkg::MAG_W-1:0]           m_peak_magnitude,
    output logic [spf_pkg::MAG_W-1:0]           m_noise_level,
    output logic                                m_peak_found
);

    spf_pkg::cfg_t        cfg_reg, cfg_next;
    logic                 e_valid, e_ready;
    spf_pkg::frame_eval_t e_data;
    logic                 r_valid, r_ready;
    spf_pkg::result_t     r_data;

    assign cfg_ready = 1'b1;

    // configuration register writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (spf_pkg::cfg_reg_t'(cfg_index))
                spf_pkg::CFG_WINDOW_FIRST: begin
                    cfg_next.window_first = cfg_data[spf_pkg::BIN_W-1:0];
                end
                spf_pkg::CFG_WINDOW_LAST: begin
                    cfg_next.window_last = cfg_data[spf_pkg::BIN_W-1:0];
                end
                spf_pkg::CFG_START_FLOOR: begin
                    cfg_next.start_floor = cfg_data[spf_pkg::MAG_W-1:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.window_first <= spf_pkg::WINDOW_FIRST_RST;
            cfg_reg.window_last  <= spf_pkg::WINDOW_LAST_RST;
            cfg_reg.start_floor  <= spf_pkg::START_FLOOR_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    spf_frame_track #(
        .FRAME_BINS (FRAME_BINS),
        .MAG_BITS   (MAG_BITS)
    ) u_frame (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_magnitude     (s_magnitude),
        .s_last_of_frame (s_last_of_frame),
        .s_clear_average (s_clear_average),
        .e_valid         (e_valid),
        .e_ready         (e_ready),
        .e_data          (e_data)
    );

    spf_noise_calc #(
        .NOISE_DIVISOR (NOISE_DIVISOR)
    ) u_noise (
        .aclk    (aclk),
        .aresetn (aresetn),
        .e_valid (e_valid),
        .e_ready (e_ready),
        .e_data  (e_data),
        .r_valid (r_valid),
        .r_ready (r_ready),
        .r_data  (r_data)
    );

    spf_result u_result (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .r_valid          (r_valid),
        .r_ready          (r_ready),
        .r_data           (r_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_peak_bin       (m_peak_bin),
        .m_peak_magnitude (m_peak_magnitude),
        .m_noise_level    (m_noise_level),
        .m_peak_found     (m_peak_found)
    );

endmodule

`default_nettype wire
